@@ src/weh_pkg.sv @@
// ----------------------------------------------------------------------------
// Weighted efficiency histogram package
// Item types, request codes and the cut-mask decoding that the histogram uses.
// ----------------------------------------------------------------------------
package weh_pkg;

    typedef enum logic [1:0] {
        REQ_ACCUMULATE = 2'd0,
        REQ_CLEAR      = 2'd1,
        REQ_READ       = 2'd2,
        REQ_RESERVED   = 2'd3
    } t_req_type;

    typedef struct packed {
        t_req_type   req_type;
        logic [7:0]  cut_mask;
        logic [6:0]  bin_l1;
        logic [6:0]  bin_tof;
        logic [6:0]  bin_inner;
        logic [6:0]  bin_tracker;
        logic [6:0]  bin_accept;
        logic [23:0] weight;
        logic [3:0]  read_select;
        logic [6:0]  read_bin;
    } t_in_item;

    typedef struct packed {
        logic [47:0] sum_weight;
        logic [63:0] sum_weight_sq;
        logic        saturated;
    } t_out_item;

    // One stored bin: both sums and the saturation mark.
    typedef struct packed {
        logic        sat;
        logic [63:0] sum_sq;
        logic [47:0] sum;
    } t_bin_word;

    localparam int unsigned BIN_WORD_W = $bits(t_bin_word);
    localparam logic [23:0] WEIGHT_ONE = 24'h01_0000;
    localparam logic [47:0] MAX_SUM    = '1;
    localparam logic [63:0] MAX_SUM_SQ = '1;

    // Whether histogram m (detector * 2 + pass) takes the event.
    function automatic logic acc_hit(input t_in_item it, input int unsigned m);
        logic phys;
        logic unb;
        logic en;
        phys = it.cut_mask[6];
        unb  = it.cut_mask[7];
        unique case (m)
            0:       en = it.cut_mask[0];
            1:       en = it.cut_mask[0] & it.cut_mask[1];
            2:       en = it.cut_mask[2];
            3:       en = it.cut_mask[2] & it.cut_mask[3];
            4:       en = it.cut_mask[4];
            5:       en = it.cut_mask[4] & it.cut_mask[5];
            6:       en = phys | unb;
            7:       en = phys;
            9:       en = phys;
            default: en = 1'b0;
        endcase
        return en;
    endfunction

    // Bin index of the event on the axis of histogram m.
    function automatic logic [6:0] acc_bin(input t_in_item it, input int unsigned m);
        logic [6:0] b;
        unique case (m >> 1)
            0:       b = it.bin_l1;
            1:       b = it.bin_tof;
            2:       b = it.bin_inner;
            3:       b = it.bin_tracker;
            4:       b = it.bin_accept;
            default: b = '0;
        endcase
        return b;
    endfunction

endpackage

@@ src/weh_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module weh_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/weighted_efficiency_histogram.sv @@
// ----------------------------------------------------------------------------
// Weighted efficiency histogram
// Accumulates weighted total and pass histograms per detector and reads bins.
// ----------------------------------------------------------------------------
// The block takes one request item per clock cycle and has a two-stage
// pipeline: the first stage decodes the cut mask, addresses the histogram
// memories and squares the weight, the second stage adds the weight and the
// squared weight with saturation and writes the bins back. Each histogram
// (detector times two, plus one for pass) lives in its own memory, so every
// event touches each memory at most once and one event per cycle is
// sustained; a write that has not yet reached the memory when the same bin
// is read again is forwarded. A read request yields one result item, read
// at the second stage and held in the output register. A clear request,
// and reset, start a sweep that zeroes one bin of every memory per cycle,
// all NUM_BINS + 2 bins, during which no item is accepted; configuration
// writes are always taken. The input is stalled only while a read waits
// behind a full, stalled output register, or during a clearing sweep.
// ----------------------------------------------------------------------------
module weighted_efficiency_histogram
    import weh_pkg::*;
#(
    parameter int unsigned NUM_BINS      = 64,
    parameter int unsigned NUM_DETECTORS = 5
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic      i_cfg_data
);

    localparam int unsigned BPH = NUM_BINS + 2;
    localparam int unsigned NM  = 2 * NUM_DETECTORS;
    localparam int unsigned AW  = $clog2(BPH);

    // Control state.
    logic          r_weighted;
    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;
    logic          r_s1_valid;
    logic          r_out_valid;
    logic [NM-1:0] r_s1_wen;
    logic [NM-1:0] r_wb_valid;

    // Payload state.
    logic            r_s1_read;
    logic            r_s1_oor;
    logic [3:0]      r_s1_sel;
    logic [23:0]     r_s1_w;
    logic [47:0]     r_s1_w2;
    logic [AW-1:0]   r_s1_addr [NM];
    logic [AW-1:0]   r_wb_addr [NM];
    t_bin_word       r_wb_data [NM];
    t_out_item       r_out;

    logic            adv;
    logic            accept;
    logic [23:0]     w_s0;
    logic [47:0]     w2_s0;
    logic [AW-1:0]   addr_s0 [NM];
    logic [NM-1:0]   wen_s0;
    logic            oor_s0;
    logic [BIN_WORD_W-1:0] rdata [NM];
    t_bin_word       cur  [NM];
    t_bin_word       upd  [NM];
    logic [NM-1:0]   we;
    logic [AW-1:0]   waddr [NM];
    t_bin_word       wdata [NM];
    t_out_item       rd_result;

    // The pipeline moves unless a read result would land on a stalled,
    // full output register.
    assign adv         = !(r_out_valid && i_out_stall && r_s1_valid && r_s1_read);
    assign o_in_stall  = r_clearing || !adv;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign w_s0  = r_weighted ? i_in_item.weight : WEIGHT_ONE;
    assign w2_s0 = w_s0 * w_s0;

    assign oor_s0 = (32'(i_in_item.read_select) >= NM) || (32'(i_in_item.read_bin) >= BPH);

    always_comb begin
        for (int unsigned m = 0; m < NM; m++) begin
            if (i_in_item.req_type == REQ_READ) begin
                addr_s0[m] = AW'(i_in_item.read_bin);
                wen_s0[m]  = 1'b0;
            end else begin
                addr_s0[m] = AW'(acc_bin(i_in_item, m));
                wen_s0[m]  = (i_in_item.req_type == REQ_ACCUMULATE)
                             && acc_hit(i_in_item, m)
                             && (32'(acc_bin(i_in_item, m)) < BPH);
            end
        end
    end

    // Second stage: forward the last write, add with saturation.
    always_comb begin
        logic [48:0] s;
        logic [64:0] sq;
        for (int unsigned m = 0; m < NM; m++) begin
            if (r_wb_valid[m] && r_wb_addr[m] == r_s1_addr[m]) begin
                cur[m] = r_wb_data[m];
            end else begin
                cur[m] = t_bin_word'(rdata[m]);
            end
            s  = {1'b0, cur[m].sum} + 49'(r_s1_w);
            sq = {1'b0, cur[m].sum_sq} + 65'(r_s1_w2);
            upd[m].sum    = s[48] ? MAX_SUM : s[47:0];
            upd[m].sum_sq = sq[64] ? MAX_SUM_SQ : sq[63:0];
            upd[m].sat    = cur[m].sat || s[48] || (s[47:0] == MAX_SUM)
                            || sq[64] || (sq[63:0] == MAX_SUM_SQ);
            if (r_clearing) begin
                we[m]    = 1'b1;
                waddr[m] = r_clr_addr;
                wdata[m] = '0;
            end else begin
                we[m]    = adv && r_s1_valid && r_s1_wen[m];
                waddr[m] = r_s1_addr[m];
                wdata[m] = upd[m];
            end
        end
    end

    always_comb begin
        rd_result = '0;
        if (!r_s1_oor) begin
            for (int unsigned m = 0; m < NM; m++) begin
                if (32'(r_s1_sel) == m) begin
                    rd_result.sum_weight    = cur[m].sum;
                    rd_result.sum_weight_sq = cur[m].sum_sq;
                    rd_result.saturated     = cur[m].sat;
                end
            end
        end
    end

    for (genvar g = 0; g < NM; g++) begin : g_hist
        weh_ram #(
            .WIDTH (BIN_WORD_W),
            .DEPTH (BPH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (we[g]),
            .i_waddr (waddr[g]),
            .i_wdata (wdata[g]),
            .i_re    (adv),
            .i_raddr (addr_s0[g]),
            .o_rdata (rdata[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weighted  <= 1'b0;
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_s1_wen    <= '0;
            r_out_valid <= 1'b0;
            r_wb_valid  <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_weighted <= i_cfg_data;
            end
            if (r_clearing) begin
                r_wb_valid <= '0;
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(BPH - 1)) begin
                    r_clearing <= 1'b0;
                end
            end else begin
                r_wb_valid <= r_wb_valid | we;
                if (accept && i_in_item.req_type == REQ_CLEAR) begin
                    r_clearing <= 1'b1;
                    r_clr_addr <= '0;
                end
            end
            if (adv) begin
                r_s1_valid <= accept;
                r_s1_wen   <= accept ? wen_s0 : '0;
                if (r_s1_valid && r_s1_read) begin
                    r_out_valid <= 1'b1;
                end else if (!i_out_stall) begin
                    r_out_valid <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_read <= (i_in_item.req_type == REQ_READ);
            r_s1_oor  <= oor_s0;
            r_s1_sel  <= i_in_item.read_select;
            r_s1_w    <= w_s0;
            r_s1_w2   <= w2_s0;
            for (int unsigned m = 0; m < NM; m++) begin
                r_s1_addr[m] <= addr_s0[m];
            end
            if (r_s1_valid && r_s1_read) begin
                r_out <= rd_result;
            end
        end
        for (int unsigned m = 0; m < NM; m++) begin
            if (we[m]) begin
                r_wb_addr[m] <= waddr[m];
                r_wb_data[m] <= wdata[m];
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
